// File: hw/rtl/lpr_pkg.sv
package lpr_pkg;

  localparam int MAX_ORDERS  = 4;
  localparam int MAX_DEGREES = 16;

  localparam int POINT_W = 24;
  localparam int VALUE_W = 48;
  localparam int ORDER_W = 2;
  localparam int DEGREE_W = 4;
  localparam int FRAC_W = 24;

  localparam int DEG_CNT_W = 5;
  localparam int ORD_CNT_W = 3;

  // register indexes (byte address is 4x index)
  localparam logic REG_DEGREE_COUNT = 1'b0;
  localparam logic REG_ORDER_COUNT  = 1'b1;

  localparam logic [DEG_CNT_W-1:0] DEG_CNT_RESET = 5'd16;
  localparam logic [ORD_CNT_W-1:0] ORD_CNT_RESET = 3'd4;

  localparam logic [VALUE_W-1:0] VALUE_POS_SAT = 48'h7FFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_NEG_SAT = 48'h8000_0000_0000;

  // round(2^24 / n), Q0.24
  function automatic logic [FRAC_W-1:0] recip(input logic [DEGREE_W-1:0] n);
    logic [FRAC_W-1:0] r;
    case (n)
      4'd2:    r = 24'd8388608;
      4'd3:    r = 24'd5592405;
      4'd4:    r = 24'd4194304;
      4'd5:    r = 24'd3355443;
      4'd6:    r = 24'd2796203;
      4'd7:    r = 24'd2396745;
      4'd8:    r = 24'd2097152;
      4'd9:    r = 24'd1864135;
      4'd10:   r = 24'd1677722;
      4'd11:   r = 24'd1525201;
      4'd12:   r = 24'd1398101;
      4'd13:   r = 24'd1290555;
      4'd14:   r = 24'd1198373;
      4'd15:   r = 24'd1118481;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/lpr_point_if.sv
interface lpr_point_if;
  logic                          valid;
  logic                          ready;
  logic [lpr_pkg::POINT_W-1:0]   eta_point;

  modport source (output valid, output eta_point, input ready);
  modport sink   (input valid, input eta_point, output ready);
endinterface

// File: hw/rtl/lpr_result_if.sv
interface lpr_result_if;
  logic                          valid;
  logic                          ready;
  logic [lpr_pkg::VALUE_W-1:0]   poly_value;
  logic [lpr_pkg::ORDER_W-1:0]   order_index;
  logic [lpr_pkg::DEGREE_W-1:0]  degree_index;
  logic                          overflowed;
  logic                          last_of_run;

  modport source (output valid, output poly_value, output order_index,
                  output degree_index, output overflowed, output last_of_run,
                  input ready);
  modport sink   (input valid, input poly_value, input order_index,
                  input degree_index, input overflowed, input last_of_run,
                  output ready);
endinterface

// File: hw/rtl/laguerre_polynomial_recurrence_top.sv
// Generalized Laguerre evaluator. Each beat on "point" carries one eta (unsigned
// Q8.16); the block answers with one beat on "result" per (m, n), m outer, n
// inner, for m < order_count and n < degree_count, values signed Q24.24,
// saturated and flagged on overflow. last_of_run marks the final beat of a point.
// Registers on the APB port: 0x0 degree_count (clamped to 2..16), 0x4
// order_count (clamped to 1..4); write them only while the block is idle.
// One point is in work at a time: point.ready is high only when idle.
// L0 and L1 are emitted straight from S_EMIT; every higher degree runs through
// S_M0..S_M5, as the one shared 35x25 multiplier is used six times (A/n, B/n,
// then the two coefficients times the 24-bit halves of L(n-1) and L(n-2)); the
// four L products are summed in an 84-bit accumulator, and S_M5 is held until
// the last one is in. The first result enters the output register from S_EMIT,
// which follows acceptance of the point, once that register is free.
// The result sits in an output register; when the receiver stalls, the
// sequencer holds at the next value until the register is free, so nothing is
// lost. Reset (rst, synchronous) empties the output, returns to idle and sets
// the registers to 16 degrees and 4 orders.
module laguerre_polynomial_recurrence_top (
  input  logic                 clk,
  input  logic                 rst,
  lpr_point_if.sink            point,
  lpr_result_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_M0   = 3'd2;
  localparam logic [2:0] S_M1   = 3'd3;
  localparam logic [2:0] S_M2   = 3'd4;
  localparam logic [2:0] S_M3   = 3'd5;
  localparam logic [2:0] S_M4   = 3'd6;
  localparam logic [2:0] S_M5   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m5_done;   // marks the final accumulate step of S_M5

  logic [lpr_pkg::DEG_CNT_W-1:0] degree_count;
  logic [lpr_pkg::ORD_CNT_W-1:0] order_count;

  logic [lpr_pkg::POINT_W-1:0]  eta;
  logic [lpr_pkg::DEGREE_W-1:0] n_idx;
  logic [lpr_pkg::ORDER_W-1:0]  m_idx;
  logic [lpr_pkg::DEGREE_W-1:0] last_deg;
  logic [lpr_pkg::ORDER_W-1:0]  last_ord;
  logic [lpr_pkg::VALUE_W-1:0]  l1;
  logic [lpr_pkg::VALUE_W-1:0]  l2;

  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [59:0] prod;
  logic [34:0]        ca;
  logic [34:0]        cb;
  logic [83:0]        acc;

  logic        res_valid;
  logic [47:0] res_value;
  logic [1:0]  res_order;
  logic [3:0]  res_degree;
  logic        res_sat;
  logic        res_last;

  // ---------------- configuration port ----------------
  logic cfg_write;
  logic [lpr_pkg::DEG_CNT_W-1:0] deg_eff;
  logic [lpr_pkg::ORD_CNT_W-1:0] ord_eff;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      lpr_pkg::REG_DEGREE_COUNT: prdata = {27'd0, degree_count};
      lpr_pkg::REG_ORDER_COUNT:  prdata = {29'd0, order_count};
      default:                   prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (degree_count < 5'd2) begin
      deg_eff = 5'd2;
    end else if (degree_count > lpr_pkg::DEG_CNT_W'(lpr_pkg::MAX_DEGREES)) begin
      deg_eff = lpr_pkg::DEG_CNT_W'(lpr_pkg::MAX_DEGREES);
    end else begin
      deg_eff = degree_count;
    end
    if (order_count == 3'd0) begin
      ord_eff = 3'd1;
    end else if (order_count > lpr_pkg::ORD_CNT_W'(lpr_pkg::MAX_ORDERS)) begin
      ord_eff = lpr_pkg::ORD_CNT_W'(lpr_pkg::MAX_ORDERS);
    end else begin
      ord_eff = order_count;
    end
  end

  // ---------------- operand selection ----------------
  logic [5:0]  a_k;
  logic [4:0]  b_k;
  logic [34:0] a_coef;
  logic [23:0] r_n;

  assign a_k    = 6'({n_idx, 1'b0}) - 6'd1 + 6'(m_idx);
  assign b_k    = 5'(n_idx) - 5'd1 + 5'(m_idx);
  assign a_coef = {5'd0, a_k, 24'd0} - {3'd0, eta, 8'd0};
  assign r_n    = lpr_pkg::recip(n_idx);

  always_comb begin
    case (state)
      S_M0: begin
        mul_a = $signed(a_coef);
        mul_b = $signed({1'b0, r_n});
      end
      S_M1: begin
        mul_a = $signed(35'(b_k));
        mul_b = $signed({1'b0, r_n});
      end
      S_M2: begin
        mul_a = $signed(ca);
        mul_b = $signed({1'b0, l1[23:0]});
      end
      S_M3: begin
        mul_a = $signed(ca);
        mul_b = $signed({l1[47], l1[47:24]});
      end
      S_M4: begin
        mul_a = $signed(cb);
        mul_b = $signed({1'b0, l2[23:0]});
      end
      S_M5: begin
        mul_a = $signed(cb);
        mul_b = $signed({l2[47], l2[47:24]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- value formation ----------------
  logic [59:0] ca_sum;
  logic [83:0] fin_sum;
  logic [12:0] fin_top;
  logic        fin_fits;
  logic [47:0] rec_value;
  logic [47:0] seed1;
  logic [47:0] emit_value;
  logic        emit_sat;
  logic        emit_fire;
  logic        deg_end;
  logic        ord_end;

  assign ca_sum   = prod + 60'h80_0000;
  assign fin_sum  = acc + 84'h80_0000;
  // bits above the 48-bit result must all match its sign bit
  assign fin_top  = fin_sum[83:71];
  assign fin_fits = (fin_top == '0) || (fin_top == '1);
  assign rec_value = fin_fits ? fin_sum[71:24] :
                     (fin_sum[83] ? lpr_pkg::VALUE_NEG_SAT : lpr_pkg::VALUE_POS_SAT);
  assign seed1 = {21'd0, 3'({1'b0, m_idx}) + 3'd1, 24'd0} - {16'd0, eta, 8'd0};

  always_comb begin
    if (n_idx == 4'd0) begin
      emit_value = 48'h1_00_0000;
      emit_sat   = 1'b0;
    end else if (n_idx == 4'd1) begin
      emit_value = seed1;
      emit_sat   = 1'b0;
    end else begin
      emit_value = rec_value;
      emit_sat   = !fin_fits;
    end
  end

  assign emit_fire = (state == S_EMIT) && (!res_valid || result.ready);
  assign deg_end   = (n_idx == last_deg);
  assign ord_end   = (m_idx == last_ord);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (point.valid) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          if (deg_end && ord_end) begin
            state_next = S_IDLE;
          end else if (deg_end || n_idx == 4'd0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_M0;
          end
        end
      end
      S_M0: state_next = S_M1;
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = S_M4;
      S_M4: state_next = S_M5;
      S_M5: begin
        if (m5_done) begin
          state_next = S_EMIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign point.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      m5_done      <= 1'b0;
      res_valid    <= 1'b0;
      degree_count <= lpr_pkg::DEG_CNT_RESET;
      order_count  <= lpr_pkg::ORD_CNT_RESET;
    end else begin
      state   <= state_next;
      m5_done <= (state == S_M5) && !m5_done;
      if (cfg_write) begin
        case (paddr[2])
          lpr_pkg::REG_DEGREE_COUNT: degree_count <= pwdata[4:0];
          lpr_pkg::REG_ORDER_COUNT:  order_count  <= pwdata[2:0];
          default: ;
        endcase
      end
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      eta      <= point.eta_point;
      n_idx    <= '0;
      m_idx    <= '0;
      last_deg <= 4'(deg_eff - 5'd1);
      last_ord <= 2'(ord_eff - 3'd1);
    end
    case (state)
      S_M1: ca  <= ca_sum[58:24];
      S_M2: cb  <= prod[34:0];
      S_M3: acc <= {{24{prod[59]}}, prod};
      S_M4: acc <= acc + {prod, 24'd0};
      S_M5: begin
        if (!m5_done) begin
          acc <= acc - {{24{prod[59]}}, prod};
        end else begin
          acc <= acc - {prod, 24'd0};
        end
      end
      default: ;
    endcase
    if (emit_fire) begin
      res_value  <= emit_value;
      res_order  <= m_idx;
      res_degree <= n_idx;
      res_sat    <= emit_sat;
      res_last   <= deg_end && ord_end;
      if (deg_end) begin
        n_idx <= '0;
        m_idx <= m_idx + 2'd1;
        l1    <= '0;
        l2    <= '0;
      end else begin
        n_idx <= n_idx + 4'd1;
        l1    <= emit_value;
        l2    <= l1;
      end
    end
  end

  assign result.valid        = res_valid;
  assign result.poly_value   = res_value;
  assign result.order_index  = res_order;
  assign result.degree_index = res_degree;
  assign result.overflowed   = res_sat;
  assign result.last_of_run  = res_last;

`ifndef SYNTHESIS
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflowed |->
      (result.poly_value == lpr_pkg::VALUE_POS_SAT) ||
      (result.poly_value == lpr_pkg::VALUE_NEG_SAT))
    else $error("saturated beat without a rail value");

  a_start: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> state == S_EMIT && n_idx == 4'd0 && m_idx == 2'd0)
    else $error("point accepted but run did not start at m=0 n=0");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_fire && deg_end && ord_end |=> point.ready && result.valid && result.last_of_run)
    else $error("final beat did not return block to idle");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> n_idx <= last_deg && m_idx <= last_ord)
    else $error("index beyond programmed count");

  a_low_exact: assert property (@(posedge clk) disable iff (rst)
    emit_fire && n_idx < 4'd2 |-> !emit_sat)
    else $error("seed degree flagged as overflow");
`endif

endmodule

// File: tb/tb_laguerre_polynomial_recurrence_top.sv
module tb_laguerre_polynomial_recurrence_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_LEN = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTS = 100;

  localparam longint HALF_LSB = 64'sd8388608;
  localparam longint VAL_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint VAL_LO = -64'sh8000_0000_0000;

  typedef struct packed {
    logic [lpr_pkg::VALUE_W-1:0]  value;
    logic [lpr_pkg::ORDER_W-1:0]  order;
    logic [lpr_pkg::DEGREE_W-1:0] degree;
    logic                         ovf;
    logic                         last;
  } lag_value_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lpr_point_if  point_bus();
  lpr_result_if result_bus();

  laguerre_polynomial_recurrence_top dut (
    .clk     (clk),
    .rst     (rst),
    .point   (point_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  lag_value_t pending_vals[$];
  int unsigned err_count;
  int unsigned cycle_count;
  logic [lpr_pkg::DEG_CNT_W-1:0] degree_reg = lpr_pkg::DEG_CNT_RESET;
  logic [lpr_pkg::ORD_CNT_W-1:0] order_reg = lpr_pkg::ORD_CNT_RESET;
  int send_idle_pct;
  int recv_stall_pct;
  int unsigned hold_ticket;
  int unsigned hold_seen;
  int unsigned hold_left;

  task automatic report_mismatch(input string what, input lag_value_t got,
                                 input lag_value_t want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display(
        "[%0t] %s: got v=%h m=%0d n=%0d ovf=%b last=%b | want v=%h m=%0d n=%0d ovf=%b last=%b",
        $time, what, got.value, got.order, got.degree, got.ovf, got.last,
        want.value, want.order, want.degree, want.ovf, want.last);
  endtask

  // Expected beats for one point at the current register settings.
  function automatic void predict_point(input logic [lpr_pkg::POINT_W-1:0] eta);
    int degs;
    int ords;
    longint eta_q;
    longint recip_n;
    longint coef_a;
    longint coef_b;
    longint prev1;
    longint prev2;
    longint val;
    logic signed [127:0] wa, wb, wx, wy, acc;
    logic sat;
    lag_value_t beat;
    degs = (degree_reg < 2) ? 2 :
           (degree_reg > lpr_pkg::MAX_DEGREES) ? lpr_pkg::MAX_DEGREES : int'(degree_reg);
    ords = (order_reg < 1) ? 1 :
           (order_reg > lpr_pkg::MAX_ORDERS) ? lpr_pkg::MAX_ORDERS : int'(order_reg);
    eta_q = {32'd0, eta, 8'd0};  // Q8.16 -> Q24.24
    for (int m = 0; m < ords; m++) begin
      prev1 = 0;
      prev2 = 0;
      for (int n = 0; n < degs; n++) begin
        sat = 1'b0;
        if (n == 0) begin
          val = longint'(1) <<< lpr_pkg::FRAC_W;
        end else if (n == 1) begin
          val = (longint'(1 + m) <<< lpr_pkg::FRAC_W) - eta_q;
        end else begin
          recip_n = ((longint'(1) <<< lpr_pkg::FRAC_W) + n / 2) / n;
          coef_a = ((((longint'(2 * n - 1 + m) <<< lpr_pkg::FRAC_W) - eta_q) * recip_n)
                    + HALF_LSB) >>> lpr_pkg::FRAC_W;
          coef_b = (((longint'(n - 1 + m) <<< lpr_pkg::FRAC_W) * recip_n) + HALF_LSB)
                   >>> lpr_pkg::FRAC_W;
          wa = coef_a;
          wb = coef_b;
          wx = prev1;
          wy = prev2;
          acc = (wa * wx - wb * wy + HALF_LSB) >>> lpr_pkg::FRAC_W;
          if (acc > VAL_HI) begin
            val = VAL_HI;
            sat = 1'b1;
          end else if (acc < VAL_LO) begin
            val = VAL_LO;
            sat = 1'b1;
          end else begin
            val = acc[63:0];
          end
        end
        prev2 = prev1;
        prev1 = val;
        beat.value = val[lpr_pkg::VALUE_W-1:0];
        beat.order = m[lpr_pkg::ORDER_W-1:0];
        beat.degree = n[lpr_pkg::DEGREE_W-1:0];
        beat.ovf = sat;
        beat.last = (m == ords - 1) && (n == degs - 1);
        pending_vals.push_back(beat);
      end
    end
  endfunction

  // Called at a rising edge; returns at the edge that accepts the beat, valid left high.
  task automatic send_point(input logic [lpr_pkg::POINT_W-1:0] eta);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      point_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_bus.valid <= 1'b1;
    point_bus.eta_point <= eta;
    do @(posedge clk); while (!point_bus.ready);
    predict_point(eta);
  endtask

  task automatic wait_idle();
    point_bus.valid <= 1'b0;
    while (pending_vals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves psel high so a following write can start its setup cycle right away.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == lpr_pkg::REG_DEGREE_COUNT) degree_reg = data[lpr_pkg::DEG_CNT_W-1:0];
    else order_reg = data[lpr_pkg::ORD_CNT_W-1:0];
  endtask

  task automatic apply_sizes(input logic [31:0] deg_word, input logic [31:0] ord_word);
    wait_idle();
    write_reg(lpr_pkg::REG_DEGREE_COUNT, deg_word);
    write_reg(lpr_pkg::REG_ORDER_COUNT, ord_word);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [lpr_pkg::POINT_W-1:0] random_eta();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return lpr_pkg::POINT_W'($urandom_range(24'h03FFFF));
      4: return lpr_pkg::POINT_W'($urandom_range(24'h0FFFFF));
      default: return lpr_pkg::POINT_W'($urandom);
    endcase
  endfunction

  task automatic test_default_settings();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_point(24'h000000);
    send_point(24'h000001);
    send_point(24'hFFFFFF);
    send_point(24'h010000);
    send_point(24'h020000);
    send_point(24'h400000);
    wait_idle();
  endtask

  // Smallest and largest sizes, clamping on both sides, junk in the upper data bits.
  task automatic test_register_extremes();
    apply_sizes(32'd2, 32'd1);
    send_point(24'h000000);
    send_point(24'hFFFFFF);
    send_point(random_eta());
    apply_sizes(32'd0, 32'd0);
    send_point(24'h018000);
    send_point(random_eta());
    apply_sizes(32'd1, 32'd7);
    send_point(24'hFFFFFF);
    send_point(random_eta());
    apply_sizes(32'd31, 32'd5);
    send_point(24'hFFFFFF);
    send_point(24'h800000);
    apply_sizes(32'hFFFF_FFF1, 32'hFFFF_FFFB);
    send_point(24'h0A0000);
    send_point(random_eta());
    apply_sizes(32'hA5A5_A5B0, 32'h5A5A_5A5C);
    send_point(24'h005555);
    send_point(24'hAAAAAA);
    wait_idle();
  endtask

  task automatic test_random_points();
    logic [31:0] junk;
    logic [4:0] deg;
    logic [2:0] ord;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (int k = 0; k < 3; k++) begin
        junk = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        deg = 5'($urandom_range(31));
        ord = 3'($urandom_range(7));
        apply_sizes({junk[31:5], deg}, {junk[31:3], ord});
        for (int i = 0; i < 25; i++) send_point(random_eta());
      end
    end
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while points keep coming.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_sizes(32'd16, 32'd4);
    hold_ticket <= hold_ticket + 1;
    for (int i = 0; i < 4; i++) send_point(random_eta());
    recv_stall_pct = 48;
    for (int i = 0; i < 4; i++) send_point(random_eta());
    wait_idle();
  endtask

  always @(posedge clk) begin : result_sink
    lag_value_t got;
    lag_value_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.value = result_bus.poly_value;
      got.order = result_bus.order_index;
      got.degree = result_bus.degree_index;
      got.ovf = result_bus.overflowed;
      got.last = result_bus.last_of_run;
      if (pending_vals.size() == 0) begin
        report_mismatch("unexpected beat", got, '0);
      end else begin
        want = pending_vals.pop_front();
        if (got !== want) report_mismatch("value mismatch", got, want);
      end
    end
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    point_bus.valid <= 1'b0;
    point_bus.eta_point <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_settings();
    test_register_extremes();
    test_random_points();
    test_output_backpressure();
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
